// File: rtl/rrtd_pkg.sv
// Shared types and constants of the round-robin task dispatcher.
package rrtd_pkg;

	localparam int SLOTS = 8;
	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);
	localparam int REM_W = 6;
	localparam int SUM_W = REM_W + 1;

	localparam logic [REM_W-1:0] REM_MAX = '1;

	localparam logic [15:0] METHOD_GET = 16'd1002;
	localparam logic [15:0] METHOD_POST = 16'd1003;
	localparam logic [15:0] METHOD_REFUSED = 16'd1010;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [15:0] method_code;
		logic [3:0] load_factor;
	} request_t;

	typedef struct packed {
		logic assigned;
		logic [2:0] slot_index;
		logic rejected;
		logic [3:0] finished_count;
		logic [3:0] busy_count;
	} result_t;

	typedef struct packed {
		logic en;
		logic [IDX_W-1:0] idx;
		logic busy;
		logic [REM_W-1:0] rem;
	} slot_wr_t;

	typedef struct packed {
		logic [SUM_W-1:0] a;
		logic [SUM_W-1:0] b;
	} alu_op_t;

endpackage

// File: rtl/rrtd_slot_file.sv
// Slot table: busy flag and remaining-time counter per worker slot.
module rrtd_slot_file (
	input logic clk,
	input logic arst_n,
	input logic [rrtd_pkg::IDX_W-1:0] rd_idx,
	input rrtd_pkg::slot_wr_t wr,
	output logic rd_busy,
	output logic [rrtd_pkg::REM_W-1:0] rd_rem
);
	import rrtd_pkg::*;

	logic [SLOTS-1:0] busy_q;
	logic [REM_W-1:0] rem_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				rem_q[i] <= '0;
			end
		end else if (wr.en) begin
			busy_q[wr.idx] <= wr.busy;
			rem_q[wr.idx] <= wr.rem;
		end
	end

	assign rd_busy = busy_q[rd_idx];
	assign rd_rem = rem_q[rd_idx];

endmodule

// File: rtl/rrtd_alu.sv
// Shared adder with saturation for duration cost and counter decrement.
module rrtd_alu (
	input rrtd_pkg::alu_op_t op,
	output logic [rrtd_pkg::REM_W-1:0] sum
);
	import rrtd_pkg::*;

	logic [SUM_W-1:0] raw;

	assign raw = op.a + op.b;
	assign sum = raw[SUM_W-1] ? REM_MAX : raw[REM_W-1:0];

endmodule

// File: rtl/round_robin_task_dispatcher_unit.sv
// Top level: sequencer of the round-robin task dispatcher.
// A tick visits every slot from slot 0 (one slot visited per cycle), then the result state;
// a request scans on from the slot after the last assigned one; a refused one skips the scan.
// Throughput: one item at a time; busy stays high until the done cycle ends.
// The result is held on result for the single cycle in which done is high.
// Reset: all slots ready, busy count zero, scan starts at slot 0.
module round_robin_task_dispatcher_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	input rrtd_pkg::request_t request,
	output logic busy,
	output logic done,
	output rrtd_pkg::result_t result
);
	import rrtd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_TICK = 4'b0010,
		ST_SCAN = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;
	logic [REM_W-1:0] dur_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] cnt_q;
	logic [IDX_W-1:0] last_q;
	logic [CNT_W-1:0] busy_total_q;
	logic [CNT_W-1:0] finished_q;
	logic assigned_q;
	logic [IDX_W-1:0] slot_q;
	logic rejected_q;

	logic rd_busy;
	logic [REM_W-1:0] rd_rem;
	slot_wr_t wr;
	alu_op_t op;
	logic [REM_W-1:0] alu_sum;
	logic [SUM_W-1:0] f1;
	logic cnt_last;

	function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(SLOTS - 1)) ? '0 : i + 1'b1;
	endfunction

	rrtd_slot_file u_slots (
		.clk(clk),
		.arst_n(arst_n),
		.rd_idx(idx_q),
		.wr(wr),
		.rd_busy(rd_busy),
		.rd_rem(rd_rem)
	);

	rrtd_alu u_alu (
		.op(op),
		.sum(alu_sum)
	);

	assign f1 = SUM_W'(request.load_factor) + 1'b1;
	assign cnt_last = (cnt_q == IDX_W'(SLOTS - 1));

	always_comb begin
		op.a = f1 << 1;
		op.b = '0;
		if (state_q == ST_TICK) begin
			op.a = SUM_W'(rd_rem);
			op.b = '1;
		end else if (request.method_code == METHOD_GET) begin
			op.b = f1;
		end else if (request.method_code == METHOD_POST) begin
			op.b = f1 << 1;
		end
	end

	always_comb begin
		wr.en = 1'b0;
		wr.idx = idx_q;
		wr.busy = 1'b0;
		wr.rem = '0;
		case (state_q)
			ST_TICK: begin
				if (rd_busy) begin
					wr.en = 1'b1;
					if (rd_rem <= REM_W'(1)) begin
						wr.busy = 1'b0;
						wr.rem = '0;
					end else begin
						wr.busy = 1'b1;
						wr.rem = alu_sum;
					end
				end
			end
			ST_SCAN: begin
				if (!rd_busy) begin
					wr.en = 1'b1;
					wr.busy = 1'b1;
					wr.rem = dur_q;
				end
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			cnt_q <= '0;
			last_q <= IDX_W'(SLOTS - 1);
			busy_total_q <= '0;
			finished_q <= '0;
			assigned_q <= 1'b0;
			slot_q <= '0;
			rejected_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						finished_q <= '0;
						assigned_q <= 1'b0;
						slot_q <= '0;
						rejected_q <= 1'b0;
						cnt_q <= '0;
						if (request.opcode == OP_TICK) begin
							idx_q <= '0;
							state_q <= ST_TICK;
						end else if (request.method_code == METHOD_REFUSED) begin
							rejected_q <= 1'b1;
							state_q <= ST_DONE;
						end else begin
							idx_q <= next_idx(last_q);
							state_q <= ST_SCAN;
						end
					end
				end
				ST_TICK: begin
					if (rd_busy && rd_rem <= REM_W'(1)) begin
						finished_q <= finished_q + 1'b1;
						if (busy_total_q != '0) begin
							busy_total_q <= busy_total_q - 1'b1;
						end
					end
					idx_q <= next_idx(idx_q);
					cnt_q <= cnt_q + 1'b1;
					if (cnt_last) begin
						state_q <= ST_DONE;
					end
				end
				ST_SCAN: begin
					if (!rd_busy) begin
						last_q <= idx_q;
						busy_total_q <= busy_total_q + 1'b1;
						assigned_q <= 1'b1;
						slot_q <= idx_q;
						state_q <= ST_DONE;
					end else begin
						idx_q <= next_idx(idx_q);
						cnt_q <= cnt_q + 1'b1;
						if (cnt_last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the cost of the accepted request for the scan.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			dur_q <= alu_sum;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	always_comb begin
		result.assigned = assigned_q;
		result.slot_index = 3'(slot_q);
		result.rejected = rejected_q;
		result.finished_count = 4'(finished_q);
		result.busy_count = 4'(busy_total_q);
	end

endmodule
